FILE: src/ertm_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler-angle rotation matrix block.
package ertm_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int WORK_W       = 34;

   typedef logic signed [WORK_W-1:0] work_type;

   localparam work_type CORDIC_GAIN_Q30 = 34'sd652032874;

   function automatic work_type atan_step(input int i);
      work_type t;
      case (i)
         0: t = 34'sd536870912;   1: t = 34'sd316933406;   2: t = 34'sd167458907;
         3: t = 34'sd85004756;    4: t = 34'sd42667331;    5: t = 34'sd21354465;
         6: t = 34'sd10679838;    7: t = 34'sd5340245;     8: t = 34'sd2670163;
         9: t = 34'sd1335087;    10: t = 34'sd667544;     11: t = 34'sd333772;
         12: t = 34'sd166886;     13: t = 34'sd83443;      14: t = 34'sd41722;
         15: t = 34'sd20861;      16: t = 34'sd10430;      17: t = 34'sd5215;
         18: t = 34'sd2608;       19: t = 34'sd1304;       20: t = 34'sd652;
         21: t = 34'sd326;        22: t = 34'sd163;        23: t = 34'sd81;
         24: t = 34'sd41;         25: t = 34'sd20;         26: t = 34'sd10;
         27: t = 34'sd5;          28: t = 34'sd3;          29: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   // Q30 product, rounded half up
   function automatic work_type mul_q30(input work_type a, input work_type b);
      logic signed [2*WORK_W-1:0] p;
      logic signed [2*WORK_W-1:0] r;
      p = a * b;
      r = (p + (68'sd1 <<< 29)) >>> 30;
      return r[WORK_W-1:0];
   endfunction

endpackage

FILE: src/ertm_cordic.sv
// Pipelined CORDIC sine/cosine, one step per stage, with quadrant fold.
module ertm_cordic
   import ertm_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] angle,
   output work_type    cos_out,
   output work_type    sin_out
);

   work_type   x_ff [0:CORDIC_STEPS];
   work_type   y_ff [0:CORDIC_STEPS];
   work_type   z_ff [0:CORDIC_STEPS];
   logic [1:0] q_ff [0:CORDIC_STEPS];
   work_type   cos_ff, sin_ff;

   logic [31:0] bias_in;
   logic [1:0]  q_in;
   logic [31:0] res_in;

   always_comb begin
      bias_in = angle + 32'h2000_0000;
      q_in    = bias_in[31:30];
      res_in  = angle - {q_in, 30'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= work_type'(signed'(res_in));
         q_ff[0] <= q_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][WORK_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step(i);
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (q_ff[CORDIC_STEPS])
            2'd0: begin
               cos_ff <= x_ff[CORDIC_STEPS];
               sin_ff <= y_ff[CORDIC_STEPS];
            end
            2'd1: begin
               cos_ff <= -y_ff[CORDIC_STEPS];
               sin_ff <= x_ff[CORDIC_STEPS];
            end
            2'd2: begin
               cos_ff <= -x_ff[CORDIC_STEPS];
               sin_ff <= -y_ff[CORDIC_STEPS];
            end
            default: begin
               cos_ff <= y_ff[CORDIC_STEPS];
               sin_ff <= -x_ff[CORDIC_STEPS];
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: src/euler_to_rotation_matrix.sv
// Top level: heading-pitch-bank angles to a saturated fixed-point 3x3 rotation matrix.
//
//   channel  | dir | tdata fields (low bit up)
//   req_     | in  | pitch_angle, heading_angle, bank_angle (ANGLE_BITS each, zero pad)
//   rsp_     | out | m00 m01 m02 m10 m11 m12 m20 m21 m22 (OUT_FRAC_BITS+2 each, pad)
//
// Pipeline: the CORDIC pipeline, then two multiply stages and one sum/round stage.
// One item per cycle when not stalled. The whole pipeline advances together and
// holds while a result waits on rsp_tready. Reset clears the valid bits only.
module euler_to_rotation_matrix
   import ertm_pkg::*;
#(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // pitch_angle, heading_angle, bank_angle
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]   rsp_tdata
);

   localparam int OW     = OUT_FRAC_BITS + 2;
   localparam int OUT_TW = ((9*OW+7)/8)*8;
   localparam int LAT    = CORDIC_LAT + 3;
   localparam int RND_SH = (OUT_FRAC_BITS < 30) ? 30 - OUT_FRAC_BITS : 1;
   localparam int SUM_W  = WORK_W + 2;

   typedef logic signed [SUM_W-1:0] sum_type;

   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [31:0]    pa, ha, ba;
   work_type       cp, sp, ch, sh, cb, sb;

   work_type shsp_ff, chsp_ff, chcb_ff, chsb_ff, shcp_ff, sbcp_ff, cbcp_ff, shcb_ff;
   work_type sbsh_ff, chcp_ff, sb1_ff, cb1_ff, nsp1_ff;
   work_type t00_ff, t01_ff, t20_ff, t21_ff;
   work_type a00_ff, a01_ff, a02_ff, a10_ff, a11_ff, a12_ff, a20_ff, a21_ff, a22_ff;
   logic [9*OW-1:0] out_ff;

   function automatic logic [OW-1:0] to_out(input sum_type v);
      sum_type r;
      sum_type one;
      one = sum_type'(1) <<< OUT_FRAC_BITS;
      if (OUT_FRAC_BITS < 30) r = (v + (sum_type'(1) <<< (RND_SH - 1))) >>> RND_SH;
      else r = v;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[OW-1:0];
   endfunction

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = OUT_TW'(out_ff);

   assign pa = {req_tdata[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
   assign ha = {req_tdata[2*ANGLE_BITS-1:ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
   assign ba = {req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};

   ertm_cordic u_pitch   (.clock, .en, .angle(pa), .cos_out(cp), .sin_out(sp));
   ertm_cordic u_heading (.clock, .en, .angle(ha), .cos_out(ch), .sin_out(sh));
   ertm_cordic u_bank    (.clock, .en, .angle(ba), .cos_out(cb), .sin_out(sb));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // first products
   always_ff @(posedge clock) begin
      if (en) begin
         shsp_ff <= mul_q30(sh, sp);
         chsp_ff <= mul_q30(ch, sp);
         chcb_ff <= mul_q30(ch, cb);
         chsb_ff <= mul_q30(ch, sb);
         shcp_ff <= mul_q30(sh, cp);
         sbcp_ff <= mul_q30(sb, cp);
         cbcp_ff <= mul_q30(cb, cp);
         shcb_ff <= mul_q30(sh, cb);
         sbsh_ff <= mul_q30(sb, sh);
         chcp_ff <= mul_q30(ch, cp);
         sb1_ff  <= sb;
         cb1_ff  <= cb;
         nsp1_ff <= -sp;
      end
   end

   // triple products
   always_ff @(posedge clock) begin
      if (en) begin
         t00_ff <= mul_q30(shsp_ff, sb1_ff);
         t01_ff <= mul_q30(shsp_ff, cb1_ff);
         t20_ff <= mul_q30(chsp_ff, sb1_ff);
         t21_ff <= mul_q30(chsp_ff, cb1_ff);
         a00_ff <= chcb_ff;
         a01_ff <= chsb_ff;
         a02_ff <= shcp_ff;
         a10_ff <= sbcp_ff;
         a11_ff <= cbcp_ff;
         a12_ff <= nsp1_ff;
         a20_ff <= shcb_ff;
         a21_ff <= sbsh_ff;
         a22_ff <= chcp_ff;
      end
   end

   // sums, rounding, saturation
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff[0*OW +: OW] <= to_out(sum_type'(a00_ff) + sum_type'(t00_ff));
         out_ff[1*OW +: OW] <= to_out(sum_type'(t01_ff) - sum_type'(a01_ff));
         out_ff[2*OW +: OW] <= to_out(sum_type'(a02_ff));
         out_ff[3*OW +: OW] <= to_out(sum_type'(a10_ff));
         out_ff[4*OW +: OW] <= to_out(sum_type'(a11_ff));
         out_ff[5*OW +: OW] <= to_out(sum_type'(a12_ff));
         out_ff[6*OW +: OW] <= to_out(sum_type'(t20_ff) - sum_type'(a20_ff));
         out_ff[7*OW +: OW] <= to_out(sum_type'(a21_ff) + sum_type'(t21_ff));
         out_ff[8*OW +: OW] <= to_out(sum_type'(a22_ff));
      end
   end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the Euler-angle to rotation matrix block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS    = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_W         = OUT_FRAC_BITS + 2;
   localparam int REQ_W         = ((3*ANGLE_BITS+7)/8)*8;
   localparam int RSP_W         = ((9*OUT_W+7)/8)*8;
   localparam int LATENCY       = 35;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_RANDOM    = 1000;

   typedef struct packed {
      logic [15:0] bank;
      logic [15:0] heading;
      logic [15:0] pitch;
   } angles_type;

   typedef logic [RSP_W-1:0] matrix_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   angles_type pending_angles[$];
   matrix_type expected_matrices[$];
   int      mismatches = 0;
   int      results_seen = 0;
   int      items_sent = 0;
   int      cycles = 0;
   bit      stimulus_done = 0;
   bit      hold_sender = 0;
   bit      req_taken = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   int      long_stall = 0;

   euler_to_rotation_matrix #(
      .ANGLE_BITS(ANGLE_BITS),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q30_product(longint a, longint b);
      return floor_div(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic longint arctan_entry(int i);
      longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                        81, 41, 20, 10, 5, 3, 1};
      return t[i];
   endfunction

   task automatic cordic_sin_cos(input logic [15:0] angle, output longint c,
                                 output longint s);
      logic [31:0] a;
      logic [1:0]  q;
      logic [31:0] ru;
      longint x, y, z, dx, dy;
      a  = {angle, 16'h0};
      q  = 2'((a + 32'h2000_0000) >> 30);
      ru = a - {q, 30'h0};
      z  = longint'($signed(ru));
      x  = 652032874;
      y  = 0;
      for (int i = 0; i < 30; i++) begin
         dx = floor_div(y, i);
         dy = floor_div(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end else begin
            x += dx; y -= dy; z += arctan_entry(i);
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic logic [OUT_W-1:0] round_saturate(longint v);
      longint one, r;
      one = 64'sd1 <<< OUT_FRAC_BITS;
      r = floor_div(v + (64'sd1 <<< (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[OUT_W-1:0];
   endfunction

   task automatic predict_matrix(input angles_type ang, output matrix_type m);
      longint cp, sp, ch, sh, cb, sb, shsp, chsp;
      longint e[9];
      cordic_sin_cos(ang.pitch, cp, sp);
      cordic_sin_cos(ang.heading, ch, sh);
      cordic_sin_cos(ang.bank, cb, sb);
      shsp = q30_product(sh, sp);
      chsp = q30_product(ch, sp);
      e[0] = q30_product(ch, cb) + q30_product(shsp, sb);
      e[1] = -q30_product(ch, sb) + q30_product(shsp, cb);
      e[2] = q30_product(sh, cp);
      e[3] = q30_product(sb, cp);
      e[4] = q30_product(cb, cp);
      e[5] = -sp;
      e[6] = -q30_product(sh, cb) + q30_product(chsp, sb);
      e[7] = q30_product(sb, sh) + q30_product(chsp, cb);
      e[8] = q30_product(ch, cp);
      m = '0;
      for (int k = 0; k < 9; k++) m[k*OUT_W +: OUT_W] = round_saturate(e[k]);
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
         1: return 16'($urandom_range(0, 7) * 8192);
         default: return 16'($urandom);
      endcase
   endfunction

   // driver: bursts and gaps, changes at falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            items_sent++;
         end
         if (!req_tvalid || req_taken) begin
            if (gap_left > 0) gap_left--;
            if (!hold_sender && gap_left == 0 && pending_angles.size() > 0) begin
               angles_type ang;
               matrix_type m;
               ang = pending_angles.pop_front();
               predict_matrix(ang, m);
               expected_matrices.push_back(m);
               req_tdata  <= REQ_W'(ang);
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (long_stall > 0) begin
            long_stall--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 8);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      req_taken = !reset && req_tvalid && req_tready;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            matrix_type exp_m;
            exp_m = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (rsp_tdata[k*OUT_W +: OUT_W] !== exp_m[k*OUT_W +: OUT_W]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d entry m%0d%0d: expected %0d got %0d",
                              results_seen, k / 3, k % 3,
                              $signed(exp_m[k*OUT_W +: OUT_W]),
                              $signed(rsp_tdata[k*OUT_W +: OUT_W]));
               end
            end
         end
      end
   end

   initial begin
      int drain;
      logic [15:0] corners[8];
      corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                  16'hFFFF, 16'h2000, 16'h0001, 16'h7FFF};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < 8; i++) begin
         pending_angles.push_back('{bank: corners[(i+5)%8], heading: corners[(i+2)%8],
                                    pitch: corners[i]});
      end
      pending_angles.push_back('{bank: 16'hFFFF, heading: 16'hFFFF, pitch: 16'hFFFF});
      pending_angles.push_back('{bank: 16'h0000, heading: 16'h0000, pitch: 16'h0000});
      pending_angles.push_back('{bank: 16'h5555, heading: 16'hAAAA, pitch: 16'h4000});
      pending_angles.push_back('{bank: 16'hAAAA, heading: 16'h5555, pitch: 16'hC000});
      for (int i = 0; i < 150; i++)
         pending_angles.push_back('{bank: rand_angle(), heading: rand_angle(),
                                    pitch: rand_angle()});
      // long receiver hold-off while items keep coming
      @(negedge clock);
      long_stall = 200;
      wait (pending_angles.size() == 0);
      // sender pause until all results are in
      hold_sender = 1;
      wait (expected_matrices.size() == 0 && !req_tvalid);
      hold_sender = 0;
      for (int i = 0; i < NUM_RANDOM - 150; i++)
         pending_angles.push_back('{bank: rand_angle(), heading: rand_angle(),
                                    pitch: rand_angle()});
      wait (pending_angles.size() == 0);
      @(negedge clock);
      wait (!req_tvalid);
      stimulus_done = 1;
      drain = 0;
      while (expected_matrices.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      mismatches += expected_matrices.size();
      $display("sent %0d angle triples, checked %0d matrices (corners, quadrant edges,",
               items_sent, results_seen);
      $display("random angles, bursty input, random and long output stalls)");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: euler_to_rotation_matrix.f
src/ertm_pkg.sv
src/ertm_cordic.sv
src/euler_to_rotation_matrix.sv
test/testbench.sv
